### rtl/core/kpec_pkg.sv
// Shared types, codes and defaults for the key press event classifier.
`timescale 1ns / 1ps
`default_nettype none

package kpec_pkg;

   // Sizing
   localparam int NUM_KEYS_DEF = 4;
   localparam int KEY_IDX_W    = 2;
   localparam int STAMP_W      = 32;
   localparam int MS_W         = 16;
   localparam int CSR_IDX_W    = 3;
   localparam int CSR_DATA_W   = 16;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_PRESSED_LEVEL = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DEBOUNCE      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SHORT_PRESS   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_LONG_PRESS    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_REPEAT        = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_DOUBLE_CLICK  = 3'd5;

   // Configuration reset values
   localparam logic            PRESSED_LEVEL_RST = 1'b0;
   localparam logic [MS_W-1:0] DEBOUNCE_RST      = 16'd20;
   localparam logic [MS_W-1:0] SHORT_PRESS_RST   = 16'd50;
   localparam logic [MS_W-1:0] LONG_PRESS_RST    = 16'd1000;
   localparam logic [MS_W-1:0] REPEAT_RST        = 16'd200;
   localparam logic [MS_W-1:0] DOUBLE_CLICK_RST  = 16'd300;

   // Per-key phase
   typedef enum logic [2:0] {
      PH_IDLE        = 3'd0,
      PH_DEBOUNCE    = 3'd1,
      PH_PRESSED     = 3'd2,
      PH_LONG        = 3'd3,
      PH_WAIT_DOUBLE = 3'd4
   } phase_type;

   // Reported events
   typedef enum logic [2:0] {
      EV_NONE    = 3'd0,
      EV_PRESS   = 3'd1,
      EV_RELEASE = 3'd2,
      EV_LONG    = 3'd3,
      EV_REPEAT  = 3'd4,
      EV_DOUBLE  = 3'd5,
      EV_SHORT   = 3'd6
   } event_type;

   // Input scan
   typedef struct packed {
      logic [KEY_IDX_W-1:0] key_index;
      logic                 pin_level;
      logic [STAMP_W-1:0]   now_ms;
   } req_type;

   // Result
   typedef struct packed {
      logic [2:0] event_res;
      logic       is_down;
   } rsp_type;

   // Configuration registers
   typedef struct packed {
      logic            pressed_level;
      logic [MS_W-1:0] debounce_ms;
      logic [MS_W-1:0] short_press_ms;
      logic [MS_W-1:0] long_press_ms;
      logic [MS_W-1:0] repeat_ms;
      logic [MS_W-1:0] double_click_ms;
   } cfg_type;

   // Per-key state record; all zero is the reset state
   typedef struct packed {
      phase_type          phase;
      logic               prev_pressed;
      logic [STAMP_W-1:0] press_stamp;
      logic [STAMP_W-1:0] release_stamp;
      logic [STAMP_W-1:0] event_stamp;
      logic               long_seen;
   } key_rec_type;

endpackage

`default_nettype wire

### rtl/core/key_press_event_classifier.sv
// Top level: scan handshake, configuration registers and result register.
// A transferred scan is held in the scan stage and then in the result register,
// which drives rsp_valid.
// Throughput: one scan per cycle while results are taken, set by the read-modify-write
// of the per-key state memory, with the last write bypassed to a following scan.
// Reset (synchronous, active high) clears the per-key valid bits, so every key
// reads as idle with zero stamps; configuration returns to its defaults at once.
`timescale 1ns / 1ps
`default_nettype none

module key_press_event_classifier
   import kpec_pkg::*;
#(
   parameter int NUM_KEYS = NUM_KEYS_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire req_type               req_data,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output rsp_type                    rsp_data,
   input  wire logic                  csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int KEY_AW = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

   cfg_type                       cfg_ff;
   logic                          s1_vld_ff;
   req_type                       s1_req_ff;
   logic [KEY_AW-1:0]             s1_addr_ff;
   logic                          s1_inr_ff;
   logic                          rsp_vld_ff;
   rsp_type                       rsp_data_ff;
   rsp_type                       rsp_data_in;

   logic                          req_xfer;
   logic                          s1_adv;
   logic [KEY_AW+KEY_IDX_W-1:0]   addr_wide;
   logic [KEY_AW-1:0]             req_addr;
   logic                          req_inr;
   logic                          wr_en;
   logic                          s1_down;
   key_rec_type                   cur_rec;
   key_rec_type                   nxt_rec;
   event_type                     ev;

   // Handshake
   assign s1_adv    = !rsp_vld_ff || rsp_ready;
   assign req_ready = !s1_vld_ff || s1_adv;
   assign req_xfer  = req_valid && req_ready;
   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_data_ff;

   // Key address and range check
   assign addr_wide = {{KEY_AW{1'b0}}, req_data.key_index};
   assign req_addr  = addr_wide[KEY_AW-1:0];
   assign req_inr   = 32'(req_data.key_index) < 32'(NUM_KEYS);

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pressed_level   <= PRESSED_LEVEL_RST;
         cfg_ff.debounce_ms     <= DEBOUNCE_RST;
         cfg_ff.short_press_ms  <= SHORT_PRESS_RST;
         cfg_ff.long_press_ms   <= LONG_PRESS_RST;
         cfg_ff.repeat_ms       <= REPEAT_RST;
         cfg_ff.double_click_ms <= DOUBLE_CLICK_RST;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_PRESSED_LEVEL: cfg_ff.pressed_level   <= csr_wdata[0];
            CSR_DEBOUNCE:      cfg_ff.debounce_ms     <= csr_wdata;
            CSR_SHORT_PRESS:   cfg_ff.short_press_ms  <= csr_wdata;
            CSR_LONG_PRESS:    cfg_ff.long_press_ms   <= csr_wdata;
            CSR_REPEAT:        cfg_ff.repeat_ms       <= csr_wdata;
            CSR_DOUBLE_CLICK:  cfg_ff.double_click_ms <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // Scan stage: hold the scan and its memory read until the result register takes it
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else if (req_xfer) begin
         s1_vld_ff <= 1'b1;
      end else if (s1_adv) begin
         s1_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s1_req_ff  <= req_data;
         s1_addr_ff <= req_addr;
         s1_inr_ff  <= req_inr;
      end
   end

   // Per-key state memory
   kpec_state_store #(
      .NUM_KEYS (NUM_KEYS)
   ) u_store (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (req_xfer),
      .rd_addr  (req_addr),
      .wr_en    (wr_en),
      .wr_addr  (s1_addr_ff),
      .wr_rec   (nxt_rec),
      .cur_addr (s1_addr_ff),
      .cur_rec  (cur_rec)
   );

   // Classify and write back
   assign s1_down = (s1_req_ff.pin_level == cfg_ff.pressed_level);
   assign wr_en   = s1_vld_ff && s1_adv && s1_inr_ff;

   kpec_classify u_classify (
      .cur_rec   (cur_rec),
      .down      (s1_down),
      .now_ms    (s1_req_ff.now_ms),
      .cfg       (cfg_ff),
      .nxt_rec   (nxt_rec),
      .event_out (ev)
   );

   always_comb begin
      rsp_data_in.event_res = s1_inr_ff ? ev : EV_NONE;
      rsp_data_in.is_down   = s1_down;
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (s1_vld_ff && s1_adv) begin
         rsp_vld_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_vld_ff && s1_adv) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

`ifndef SYNTHESIS
   // A stalled scan keeps its key and stays in the stage
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      (s1_vld_ff && !s1_adv) |=> (s1_vld_ff && $stable(s1_addr_ff)))
      else $error("scan stage lost a stalled scan");

   // Memory is written only by a scan leaving the stage for an existing key
   a_wr_owner: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (s1_vld_ff && s1_inr_ff && s1_adv))
      else $error("state write without a leaving scan");

   // A scan leaving the stage always shows up as a result
   a_rsp_follow: assert property (@(posedge clock) disable iff (reset)
      (s1_vld_ff && s1_adv) |=> rsp_vld_ff)
      else $error("scan left the stage without a result");

   // An out-of-range key never reports an event
   a_oor_none: assert property (@(posedge clock) disable iff (reset)
      (s1_vld_ff && s1_adv && !s1_inr_ff) |=> (rsp_data_ff.event_res == EV_NONE))
      else $error("event reported for an absent key");

   // Reset empties both stages
   a_reset_empty: assert property (@(posedge clock)
      reset |=> (!s1_vld_ff && !rsp_vld_ff))
      else $error("pipeline not empty after reset");
`endif

endmodule

`default_nettype wire

### rtl/core/kpec_state_store.sv
// Per-key state memory with valid bits and forwarding of the last write.
`timescale 1ns / 1ps
`default_nettype none

module kpec_state_store
   import kpec_pkg::*;
#(
   parameter int NUM_KEYS = NUM_KEYS_DEF,
   localparam int KEY_AW  = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              rd_en,
   input  wire logic [KEY_AW-1:0] rd_addr,
   input  wire logic              wr_en,
   input  wire logic [KEY_AW-1:0] wr_addr,
   input  wire key_rec_type       wr_rec,
   input  wire logic [KEY_AW-1:0] cur_addr,
   output key_rec_type            cur_rec
);

   key_rec_type             store_ff [NUM_KEYS];
   key_rec_type             rd_data_ff;
   logic [NUM_KEYS-1:0]     vld_ff;
   key_rec_type             fwd_rec_ff;
   logic [KEY_AW-1:0]       fwd_addr_ff;
   logic                    fwd_vld_ff;

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_rec;
      end
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   // Track written entries and hold the most recent write for bypass
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff     <= '0;
         fwd_vld_ff <= 1'b0;
      end else if (wr_en) begin
         vld_ff[wr_addr] <= 1'b1;
         fwd_vld_ff      <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         fwd_rec_ff  <= wr_rec;
         fwd_addr_ff <= wr_addr;
      end
   end

   // Select bypass, stored record, or reset record
   always_comb begin
      if (fwd_vld_ff && (fwd_addr_ff == cur_addr)) begin
         cur_rec = fwd_rec_ff;
      end else if (vld_ff[cur_addr]) begin
         cur_rec = rd_data_ff;
      end else begin
         cur_rec = '0;
      end
   end

endmodule

`default_nettype wire

### rtl/core/kpec_classify.sv
// Next-state and event logic for one key scan.
`timescale 1ns / 1ps
`default_nettype none

module kpec_classify
   import kpec_pkg::*;
(
   input  wire key_rec_type              cur_rec,
   input  wire logic                     down,
   input  wire logic [STAMP_W-1:0]       now_ms,
   input  wire cfg_type                  cfg,
   output key_rec_type                   nxt_rec,
   output event_type                     event_out
);

   logic                edge_seen;
   logic [STAMP_W-1:0]  since_press;
   logic [STAMP_W-1:0]  since_release;
   logic [STAMP_W-1:0]  since_event;
   logic [STAMP_W-1:0]  debounce_w;
   logic [STAMP_W-1:0]  short_w;
   logic [STAMP_W-1:0]  long_w;
   logic [STAMP_W-1:0]  repeat_w;
   logic [STAMP_W-1:0]  double_w;

   // Wrapping time differences and widened thresholds
   assign edge_seen     = down && !cur_rec.prev_pressed;
   assign since_press   = now_ms - cur_rec.press_stamp;
   assign since_release = now_ms - cur_rec.release_stamp;
   assign since_event   = now_ms - cur_rec.event_stamp;
   assign debounce_w    = STAMP_W'(cfg.debounce_ms);
   assign short_w       = STAMP_W'(cfg.short_press_ms);
   assign long_w        = STAMP_W'(cfg.long_press_ms);
   assign repeat_w      = STAMP_W'(cfg.repeat_ms);
   assign double_w      = STAMP_W'(cfg.double_click_ms);

   // Advance the key's phase
   always_comb begin
      nxt_rec   = cur_rec;
      event_out = EV_NONE;
      unique case (cur_rec.phase)
         PH_IDLE: begin
            if (edge_seen) begin
               nxt_rec.phase       = PH_DEBOUNCE;
               nxt_rec.press_stamp = now_ms;
            end
         end
         PH_DEBOUNCE: begin
            if (!down) begin
               nxt_rec.phase = PH_IDLE;
            end else if (since_press >= debounce_w) begin
               nxt_rec.phase     = PH_PRESSED;
               nxt_rec.long_seen = 1'b0;
               event_out         = EV_PRESS;
            end
         end
         PH_PRESSED: begin
            if (!down) begin
               nxt_rec.release_stamp = now_ms;
               event_out             = EV_RELEASE;
               if ((since_press >= short_w) && (since_press < long_w)) begin
                  nxt_rec.event_stamp = now_ms;
                  nxt_rec.phase       = PH_WAIT_DOUBLE;
               end else begin
                  nxt_rec.phase = PH_IDLE;
               end
            end else if (!cur_rec.long_seen && (since_press >= long_w)) begin
               nxt_rec.long_seen   = 1'b1;
               nxt_rec.phase       = PH_LONG;
               nxt_rec.event_stamp = now_ms;
               event_out           = EV_LONG;
            end
         end
         PH_LONG: begin
            if (!down) begin
               nxt_rec.phase = PH_IDLE;
               event_out     = EV_RELEASE;
            end else if (since_event >= repeat_w) begin
               nxt_rec.event_stamp = now_ms;
               event_out           = EV_REPEAT;
            end
         end
         PH_WAIT_DOUBLE: begin
            if (edge_seen) begin
               event_out           = (since_release <= double_w) ? EV_DOUBLE : EV_SHORT;
               nxt_rec.phase       = PH_DEBOUNCE;
               nxt_rec.press_stamp = now_ms;
            end else if (since_release > double_w) begin
               event_out     = EV_SHORT;
               nxt_rec.phase = PH_IDLE;
            end
         end
         default: begin
            nxt_rec.phase = PH_IDLE;
         end
      endcase
      nxt_rec.prev_pressed = down;
   end

endmodule

`default_nettype wire

### tb/key_event_checker.sv
// Scoreboard for the key press event classifier: predicts each scan's event and checks results.
`timescale 1ns / 1ps

module key_event_checker
   import kpec_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   input  wire logic                  req_ready,
   input  wire req_type               req_data,
   input  wire logic                  rsp_valid,
   input  wire logic                  rsp_ready,
   input  wire rsp_type               rsp_data,
   input  wire logic                  csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   output int                         waiting_cnt,
   output int                         mismatch_total
);

   localparam int KEY_COUNT = NUM_KEYS_DEF;

   // Configuration mirror
   logic            lvl_q;
   logic [MS_W-1:0] debounce_q;
   logic [MS_W-1:0] short_q;
   logic [MS_W-1:0] long_q;
   logic [MS_W-1:0] repeat_q;
   logic [MS_W-1:0] double_q;

   // Per-key tracking state
   phase_type          key_phase [KEY_COUNT];
   logic               was_down  [KEY_COUNT];
   logic [STAMP_W-1:0] press_t   [KEY_COUNT];
   logic [STAMP_W-1:0] release_t [KEY_COUNT];
   logic [STAMP_W-1:0] last_ev_t [KEY_COUNT];
   logic               long_hit  [KEY_COUNT];

   // Events still owed by the block, oldest first
   rsp_type expected_events [$];

   initial begin
      waiting_cnt    = 0;
      mismatch_total = 0;
   end

   // Advance one key's machine by one scan and return the event it reports
   function automatic rsp_type classify_scan(req_type scan);
      rsp_type            res;
      int                 k;
      logic               down;
      logic               rise;
      logic [STAMP_W-1:0] since_press;
      logic [STAMP_W-1:0] since_release;
      event_type          ev;
      k    = int'(scan.key_index);
      down = (scan.pin_level == lvl_q);
      ev   = EV_NONE;
      if (k < KEY_COUNT) begin
         rise          = down && !was_down[k];
         since_press   = scan.now_ms - press_t[k];
         since_release = scan.now_ms - release_t[k];
         case (key_phase[k])
            PH_IDLE: begin
               if (rise) begin
                  key_phase[k] = PH_DEBOUNCE;
                  press_t[k]   = scan.now_ms;
               end
            end
            PH_DEBOUNCE: begin
               if (!down) begin
                  key_phase[k] = PH_IDLE;
               end else if (since_press >= {16'd0, debounce_q}) begin
                  key_phase[k] = PH_PRESSED;
                  ev           = EV_PRESS;
                  long_hit[k]  = 1'b0;
               end
            end
            PH_PRESSED: begin
               if (!down) begin
                  release_t[k] = scan.now_ms;
                  // a click waits for a possible second press, others go straight to idle
                  if (since_press >= {16'd0, short_q} && since_press < {16'd0, long_q}) begin
                     last_ev_t[k] = scan.now_ms;
                     key_phase[k] = PH_WAIT_DOUBLE;
                  end else begin
                     key_phase[k] = PH_IDLE;
                  end
                  ev = EV_RELEASE;
               end else if (!long_hit[k] && since_press >= {16'd0, long_q}) begin
                  long_hit[k]  = 1'b1;
                  key_phase[k] = PH_LONG;
                  ev           = EV_LONG;
                  last_ev_t[k] = scan.now_ms;
               end
            end
            PH_LONG: begin
               if (!down) begin
                  key_phase[k] = PH_IDLE;
                  ev           = EV_RELEASE;
               end else if (scan.now_ms - last_ev_t[k] >= {16'd0, repeat_q}) begin
                  ev           = EV_REPEAT;
                  last_ev_t[k] = scan.now_ms;
               end
            end
            PH_WAIT_DOUBLE: begin
               if (rise) begin
                  // late second press still restarts debouncing
                  ev           = (since_release <= {16'd0, double_q}) ? EV_DOUBLE : EV_SHORT;
                  key_phase[k] = PH_DEBOUNCE;
                  press_t[k]   = scan.now_ms;
               end else if (since_release > {16'd0, double_q}) begin
                  ev           = EV_SHORT;
                  key_phase[k] = PH_IDLE;
               end
            end
            default: begin
               key_phase[k] = PH_IDLE;
            end
         endcase
         was_down[k] = down;
      end
      res.event_res = ev;
      res.is_down   = down;
      return res;
   endfunction

   // Compare result transfers, predict scan transfers, track register writes
   always @(posedge clock) begin : track
      rsp_type want;
      if (reset) begin
         lvl_q      = PRESSED_LEVEL_RST;
         debounce_q = DEBOUNCE_RST;
         short_q    = SHORT_PRESS_RST;
         long_q     = LONG_PRESS_RST;
         repeat_q   = REPEAT_RST;
         double_q   = DOUBLE_CLICK_RST;
         for (int k = 0; k < KEY_COUNT; k++) begin
            key_phase[k] = PH_IDLE;
            was_down[k]  = 1'b0;
            press_t[k]   = '0;
            release_t[k] = '0;
            last_ev_t[k] = '0;
            long_hit[k]  = 1'b0;
         end
         expected_events.delete();
         waiting_cnt <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_events.size() == 0) begin
               $error("result transfer with nothing expected: event_res=%0d is_down=%0d",
                      rsp_data.event_res, rsp_data.is_down);
               mismatch_total++;
            end else begin
               want = expected_events.pop_front();
               if (rsp_data.event_res !== want.event_res) begin
                  $error("event_res mismatch: expected %0d, actual %0d",
                         want.event_res, rsp_data.event_res);
                  mismatch_total++;
               end
               if (rsp_data.is_down !== want.is_down) begin
                  $error("is_down mismatch: expected %0d, actual %0d",
                         want.is_down, rsp_data.is_down);
                  mismatch_total++;
               end
            end
         end
         if (req_valid && req_ready) begin
            expected_events.push_back(classify_scan(req_data));
         end
         if (csr_wr_en) begin
            case (csr_index)
               CSR_PRESSED_LEVEL: lvl_q      = csr_wdata[0];
               CSR_DEBOUNCE:      debounce_q = csr_wdata;
               CSR_SHORT_PRESS:   short_q    = csr_wdata;
               CSR_LONG_PRESS:    long_q     = csr_wdata;
               CSR_REPEAT:        repeat_q   = csr_wdata;
               CSR_DOUBLE_CLICK:  double_q   = csr_wdata;
               default: ;
            endcase
         end
         waiting_cnt <= expected_events.size();
      end
   end

endmodule

### tb/tb_key_press_event_classifier.sv
// Testbench top for the key press event classifier: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_key_press_event_classifier;
   import kpec_pkg::*;

   localparam int TIMEOUT_NS      = 5_000_000;
   localparam int HOLD_CYCLES     = 300;
   localparam int DRAIN_PAUSE     = 6;
   localparam int PHASE_COUNT     = 8;
   localparam int SCANS_PER_PHASE = 75;

   // Register settings used by the phases
   localparam int SET_SMALL  = 0;
   localparam int SET_ZERO   = 1;
   localparam int SET_MAX    = 2;
   localparam int SET_RANDOM = 3;

   // Register indexes that the block must ignore
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_LO = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_HI = 3'd7;

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_type               req_data  = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   int pending_cnt;
   int fail_count;

   // Stimulus-side state
   logic [STAMP_W-1:0] now_ms = '0;
   logic               cfg_lvl;
   int unsigned        cfg_deb;
   int unsigned        cfg_short;
   int unsigned        cfg_long;
   int unsigned        cfg_repeat;
   int unsigned        cfg_double;
   int unsigned        gap_pct        = 0;
   int unsigned        stall_pct      = 0;
   int unsigned        hold_token     = 0;
   int unsigned        hold_seen      = 0;
   int unsigned        hold_left      = 0;
   int                 scan_total     = 0;
   int                 settings_total = 0;

   always #5 clock = ~clock;

   key_press_event_classifier u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   key_event_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data       (rsp_data),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .waiting_cnt    (pending_cnt),
      .mismatch_total (fail_count)
   );

   // Drive result ready: random stalls, or a long hold-off when one is requested
   always @(posedge clock) begin
      if (hold_left != 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_token != hold_seen) begin
         hold_seen <= hold_token;
         hold_left <= HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // Offer one scan, after an optional gap, and hold it until the transfer
   task automatic scan_at(input logic [KEY_IDX_W-1:0] key, input logic pin,
                          input logic [STAMP_W-1:0] stamp);
      req_type scan;
      scan.key_index = key;
      scan.pin_level = pin;
      scan.now_ms    = stamp;
      if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= scan;
      do @(posedge clock); while (!req_ready);
      scan_total++;
   endtask

   // Advance time and scan one key, sometimes after a stray scan of another key
   task automatic scan_key(input int key, input logic down, input int unsigned step);
      now_ms = now_ms + step;
      if ($urandom_range(4) == 0) begin
         scan_at(KEY_IDX_W'((key + $urandom_range(1, 3)) % 4), 1'($urandom_range(1)),
                 now_ms);
      end
      scan_at(KEY_IDX_W'(key), down ? cfg_lvl : ~cfg_lvl, now_ms);
   endtask

   // One press gesture: bounce, press, hold of some length, release, then follow-up
   task automatic run_gesture(input int key);
      int unsigned mode;
      int unsigned hold;
      int unsigned steps;
      mode = $urandom_range(2);
      repeat ($urandom_range(2)) begin
         scan_key(key, 1'b1, $urandom_range(3));
         scan_key(key, 1'b0, $urandom_range(3));
      end
      scan_key(key, 1'b1, $urandom_range(1, 40));
      scan_key(key, 1'b1, ($urandom_range(9) == 0) ? $urandom_range(cfg_deb)
                                                   : cfg_deb + $urandom_range(3));
      case (mode)
         0:       hold = $urandom_range(cfg_short);
         1:       hold = $urandom_range(cfg_short, cfg_long);
         default: hold = cfg_long + $urandom_range(4 * cfg_repeat + 3);
      endcase
      steps = (mode == 2) ? $urandom_range(3, 8) : $urandom_range(1, 3);
      repeat (steps) scan_key(key, 1'b1, hold / steps + $urandom_range(1));
      scan_key(key, 1'b0, $urandom_range(2));
      if ($urandom_range(1)) begin
         scan_key(key, 1'b1, $urandom_range(cfg_double + cfg_double / 4 + 1));
      end else begin
         repeat ($urandom_range(1, 3)) scan_key(key, 1'b0, $urandom_range(cfg_double + 2));
      end
   endtask

   // Stop offering and wait until every owed result has arrived
   task automatic settle();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_cnt != 0);
      repeat (DRAIN_PAUSE) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
   endtask

   // Mostly short thresholds, now and then anything up to the full range
   function automatic int unsigned pick_ms();
      return ($urandom_range(7) == 0) ? $urandom_range(65535) : $urandom_range(1, 120);
   endfunction

   // Write every register; the block must be idle
   task automatic apply_settings(input int kind, input logic lvl);
      logic [CSR_DATA_W-1:0] lvl_word;
      cfg_lvl = lvl;
      case (kind)
         SET_SMALL: begin
            cfg_deb = 2; cfg_short = 5; cfg_long = 30; cfg_repeat = 4; cfg_double = 12;
         end
         SET_ZERO: begin
            cfg_deb = 0; cfg_short = 0; cfg_long = 0; cfg_repeat = 0; cfg_double = 0;
         end
         SET_MAX: begin
            cfg_deb = 65535; cfg_short = 65535; cfg_long = 65535;
            cfg_repeat = 65535; cfg_double = 65535;
         end
         default: begin
            cfg_deb    = pick_ms();
            cfg_short  = pick_ms();
            cfg_long   = pick_ms();
            cfg_repeat = pick_ms();
            cfg_double = pick_ms();
         end
      endcase
      // upper bits of the level word are junk the block must drop
      lvl_word    = CSR_DATA_W'($urandom);
      lvl_word[0] = lvl;
      write_reg(CSR_PRESSED_LEVEL, lvl_word);
      write_reg(CSR_DEBOUNCE, cfg_deb[MS_W-1:0]);
      write_reg(CSR_SHORT_PRESS, cfg_short[MS_W-1:0]);
      write_reg(CSR_LONG_PRESS, cfg_long[MS_W-1:0]);
      write_reg(CSR_REPEAT, cfg_repeat[MS_W-1:0]);
      write_reg(CSR_DOUBLE_CLICK, cfg_double[MS_W-1:0]);
      write_reg($urandom_range(1) ? CSR_UNUSED_HI : CSR_UNUSED_LO, CSR_DATA_W'($urandom));
      csr_wr_en <= 1'b0;
      settings_total++;
   endtask

   // Main sequence
   initial begin : stimulus
      int phase_start;
      cfg_lvl    = PRESSED_LEVEL_RST;
      cfg_deb    = DEBOUNCE_RST;
      cfg_short  = SHORT_PRESS_RST;
      cfg_long   = LONG_PRESS_RST;
      cfg_repeat = REPEAT_RST;
      cfg_double = DOUBLE_CLICK_RST;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed scans at reset settings; pin low means pressed
      // click then double click, then a click that times out into a short press
      scan_at(0, 1'b0, 100);
      scan_at(0, 1'b0, 125);
      scan_at(0, 1'b1, 200);
      scan_at(0, 1'b0, 350);
      scan_at(0, 1'b0, 380);
      scan_at(0, 1'b1, 400);
      scan_at(0, 1'b1, 800);
      // debounce not yet met, press, long press, repeat, release
      scan_at(1, 1'b0, 1000);
      scan_at(1, 1'b0, 1010);
      scan_at(1, 1'b0, 1020);
      scan_at(1, 1'b0, 2000);
      scan_at(1, 1'b0, 2199);
      scan_at(1, 1'b0, 2200);
      scan_at(1, 1'b1, 2500);
      // release after a long hold with no long press seen
      scan_at(2, 1'b0, 3000);
      scan_at(2, 1'b0, 3030);
      scan_at(2, 1'b1, 4100);
      // release too short for a click
      scan_at(3, 1'b0, 5000);
      scan_at(3, 1'b0, 5020);
      scan_at(3, 1'b1, 5030);
      // late second press after the double-click window closed
      scan_at(0, 1'b0, 6000);
      scan_at(0, 1'b0, 6020);
      scan_at(0, 1'b1, 6100);
      scan_at(0, 1'b0, 6500);
      // bounce back to idle, then a debounce across the timestamp wrap
      scan_at(2, 1'b0, 7000);
      scan_at(2, 1'b1, 7005);
      scan_at(3, 1'b0, 32'hFFFF_FFF0);
      scan_at(3, 1'b0, 32'h0000_0010);

      // Random phases, each with its own settings and idling pattern
      for (int p = 0; p < PHASE_COUNT; p++) begin
         settle();
         now_ms = $urandom;
         case (p)
            0: apply_settings(SET_SMALL, 1'b1);
            1: apply_settings(SET_ZERO, 1'b0);
            2: begin
               apply_settings(SET_MAX, 1'b1);
               now_ms = 32'hFFFE_0000;
            end
            3: begin
               apply_settings(SET_SMALL, 1'b0);
               now_ms = 32'hFFFF_FF80;
            end
            default: apply_settings(SET_RANDOM, 1'($urandom_range(1)));
         endcase
         case (p % 4)
            0: begin gap_pct = 0;  stall_pct <= 0;  end
            1: begin gap_pct = 48; stall_pct <= 0;  end
            2: begin gap_pct = 0;  stall_pct <= 48; end
            default: begin gap_pct = 22; stall_pct <= 22; end
         endcase
         // hold off results while scans keep coming, so the block backs up
         if (p == 4) begin
            hold_token <= hold_token + 1;
         end
         phase_start = scan_total;
         while (scan_total - phase_start < SCANS_PER_PHASE) begin
            if ($urandom_range(99) < 80) begin
               run_gesture($urandom_range(3));
            end else begin
               repeat ($urandom_range(1, 3)) begin
                  scan_at(KEY_IDX_W'($urandom_range(3)), 1'($urandom_range(1)), $urandom);
               end
            end
         end
      end
      settle();

      $display("Run covered %0d scans over %0d register settings, zero and full-scale included,",
               scan_total, settings_total);
      $display("with sender gaps, result stalls and a %0d-cycle result hold-off.", HOLD_CYCLES);
      if (fail_count == 0 && pending_cnt == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   // Hang guard
   initial begin
      #(TIMEOUT_NS);
      $display("Verification failed");
      $finish;
   end

endmodule
